// ----- rtl/rational_accumulator_add_multiply_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rational accumulator
// Implication checks with a synchronous reset that disables them.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ACCUMULATOR_ADD_MULTIPLY_ASSERT_SVH
`define RATIONAL_ACCUMULATOR_ADD_MULTIPLY_ASSERT_SVH

// Same-cycle implication.
`define RAAM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RAAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/raam_pkg.sv -----
// ----------------------------------------------------------------------------
// raam_pkg
// Shared command codes, datapath operations and control structs.
// ----------------------------------------------------------------------------
`default_nettype none
package raam_pkg;

   // Item commands
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_ADD  = 2'd1;
   localparam logic [1:0] CMD_MUL  = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZDEN = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef logic [3:0] op_type;

   localparam op_type OP_IDLE       = 4'd0;
   localparam op_type OP_LATCH      = 4'd1;
   localparam op_type OP_MUL0       = 4'd2;
   localparam op_type OP_MUL1       = 4'd3;
   localparam op_type OP_FORM       = 4'd4;
   localparam op_type OP_ZERO       = 4'd5;
   localparam op_type OP_GCD_INIT   = 4'd6;
   localparam op_type OP_GCD_STEP   = 4'd7;
   localparam op_type OP_DIV_N_INIT = 4'd8;
   localparam op_type OP_DIV_D_INIT = 4'd9;
   localparam op_type OP_DIV_STEP   = 4'd10;
   localparam op_type OP_SAVE_QD    = 4'd11;
   localparam op_type OP_FINISH     = 4'd12;

   typedef struct packed {
      op_type     op;
      logic       commit;
      logic [1:0] code;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       d_zero;
      logic       rn_zero;
      logic       gcd_done;
      logic       div_done;
      logic       fits;
   } dp_stat_type;

endpackage
`default_nettype wire

// ----- rtl/raam_datapath.sv -----
// ----------------------------------------------------------------------------
// raam_datapath
// Accumulator, shared multiplier, binary gcd and restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module raam_datapath #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  raam_pkg::dp_cmd_type   dp_cmd,
   output raam_pkg::dp_stat_type  dp_stat,
   input  logic [1:0]             req_command,
   input  logic signed [31:0]     req_operand_numerator,
   input  logic signed [31:0]     req_operand_denominator,
   output logic signed [31:0]     rsp_result_numerator,
   output logic [30:0]            rsp_result_denominator,
   output logic [1:0]             rsp_status
);
   import raam_pkg::*;

   localparam logic [63:0] LIMIT = 64'd1 << (VALUE_WIDTH - 1);

   logic [31:0] acc_num_ff, acc_num_in;
   logic [30:0] acc_den_ff, acc_den_in;
   logic [1:0]  cmd_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic        a_neg_ff, c_neg_ff, r_neg_ff;
   logic [63:0] t1_ff, t2_ff, rn_ff, rd_ff;
   logic [63:0] u_ff, v_ff, g_ff, dvd_ff, rem_ff, qn_ff, qd_ff;
   logic [5:0]  k_ff;
   logic [6:0]  cnt_ff;
   logic [31:0] rsp_num_ff;
   logic [30:0] rsp_den_ff;
   logic [1:0]  rsp_st_ff;

   logic [31:0] mul_x, mul_y;
   logic [63:0] prod;
   logic [64:0] rem_sh;
   logic        rem_ge;
   logic [63:0] gcd_val;
   logic [31:0] c_raw_mag, d_raw_mag, a_raw_mag;

   assign a_raw_mag = acc_num_ff[31] ? (~acc_num_ff + 32'd1) : acc_num_ff;
   assign c_raw_mag = req_operand_numerator[31] ?
                      (~req_operand_numerator + 32'd1) : req_operand_numerator;
   assign d_raw_mag = req_operand_denominator[31] ?
                      (~req_operand_denominator + 32'd1) : req_operand_denominator;

   // One shared multiplier, operands picked by the step
   always_comb begin
      mul_x = b_ff;
      mul_y = d_ff;
      case (dp_cmd.op)
         OP_MUL0: begin
            mul_x = a_ff;
            mul_y = (cmd_ff == CMD_MUL) ? c_ff : d_ff;
         end
         OP_MUL1: begin
            mul_x = c_ff;
            mul_y = b_ff;
         end
         default: begin
            mul_x = b_ff;
            mul_y = d_ff;
         end
      endcase
   end
   assign prod = 64'(mul_x) * 64'(mul_y);

   assign rem_sh  = {rem_ff, dvd_ff[63]};
   assign rem_ge  = rem_sh >= {1'b0, g_ff};
   assign gcd_val = ((u_ff == 64'd0) ? v_ff : u_ff) << k_ff;

   assign acc_num_in = r_neg_ff ? (~qn_ff[31:0] + 32'd1) : qn_ff[31:0];
   assign acc_den_in = qd_ff[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_num_ff <= '0;
         acc_den_ff <= 31'd1;
      end else if (dp_cmd.op == OP_FINISH && dp_cmd.commit) begin
         acc_num_ff <= acc_num_in;
         acc_den_ff <= acc_den_in;
      end
   end

   always_ff @(posedge clock) begin
      case (dp_cmd.op)
         OP_LATCH: begin
            cmd_ff   <= req_command;
            a_ff     <= a_raw_mag;
            a_neg_ff <= acc_num_ff[31];
            b_ff     <= {1'b0, acc_den_ff};
            c_ff     <= c_raw_mag;
            d_ff     <= d_raw_mag;
            c_neg_ff <= req_operand_numerator[31] ^ req_operand_denominator[31];
         end
         OP_MUL0: t1_ff <= prod;
         OP_MUL1: t2_ff <= prod;
         OP_FORM: begin
            case (cmd_ff)
               CMD_LOAD: begin
                  rn_ff    <= 64'(c_ff);
                  rd_ff    <= 64'(d_ff);
                  r_neg_ff <= c_neg_ff;
               end
               CMD_MUL: begin
                  rn_ff    <= t1_ff;
                  rd_ff    <= prod;
                  r_neg_ff <= a_neg_ff ^ c_neg_ff;
               end
               default: begin
                  rd_ff <= prod;
                  if (a_neg_ff == c_neg_ff) begin
                     rn_ff    <= t1_ff + t2_ff;
                     r_neg_ff <= a_neg_ff;
                  end else if (t1_ff >= t2_ff) begin
                     rn_ff    <= t1_ff - t2_ff;
                     r_neg_ff <= a_neg_ff;
                  end else begin
                     rn_ff    <= t2_ff - t1_ff;
                     r_neg_ff <= c_neg_ff;
                  end
               end
            endcase
         end
         OP_ZERO: begin
            qn_ff    <= '0;
            qd_ff    <= 64'd1;
            r_neg_ff <= 1'b0;
         end
         OP_GCD_INIT: begin
            u_ff <= rn_ff;
            v_ff <= rd_ff;
            k_ff <= '0;
         end
         OP_GCD_STEP: begin
            if (!u_ff[0] && !v_ff[0]) begin
               u_ff <= u_ff >> 1;
               v_ff <= v_ff >> 1;
               k_ff <= k_ff + 6'd1;
            end else if (!u_ff[0]) begin
               u_ff <= u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_ff <= v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_ff <= u_ff - v_ff;
            end else begin
               v_ff <= v_ff - u_ff;
            end
         end
         OP_DIV_N_INIT: begin
            g_ff   <= gcd_val;
            dvd_ff <= rn_ff;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         OP_DIV_D_INIT: begin
            qn_ff  <= dvd_ff;
            dvd_ff <= rd_ff;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         OP_DIV_STEP: begin
            rem_ff <= rem_ge ? 64'(rem_sh - {1'b0, g_ff}) : rem_sh[63:0];
            dvd_ff <= {dvd_ff[62:0], rem_ge};
            cnt_ff <= cnt_ff + 7'd1;
         end
         OP_SAVE_QD: qd_ff <= dvd_ff;
         OP_FINISH: begin
            rsp_st_ff  <= dp_cmd.code;
            rsp_num_ff <= dp_cmd.commit ? acc_num_in : acc_num_ff;
            rsp_den_ff <= dp_cmd.commit ? acc_den_in : acc_den_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      dp_stat.cmd      = cmd_ff;
      dp_stat.d_zero   = (d_ff == 32'd0);
      dp_stat.rn_zero  = (rn_ff == 64'd0);
      dp_stat.gcd_done = (u_ff == 64'd0) || (v_ff == 64'd0);
      dp_stat.div_done = (cnt_ff == 7'd64);
      dp_stat.fits     = (qd_ff <= LIMIT - 64'd1) &&
                         (qn_ff <= (r_neg_ff ? LIMIT : LIMIT - 64'd1));
   end

   assign rsp_result_numerator   = rsp_num_ff;
   assign rsp_result_denominator = rsp_den_ff;
   assign rsp_status             = rsp_st_ff;

endmodule
`default_nettype wire

// ----- rtl/raam_ctrl.sv -----
// ----------------------------------------------------------------------------
// raam_ctrl
// Sequencer that steps the datapath through one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module raam_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output raam_pkg::dp_cmd_type  dp_cmd,
   input  raam_pkg::dp_stat_type dp_stat
);
   import raam_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_MUL1   = 4'd2;
   localparam logic [3:0] S_FORM   = 4'd3;
   localparam logic [3:0] S_ZCHK   = 4'd4;
   localparam logic [3:0] S_GCD    = 4'd5;
   localparam logic [3:0] S_DIVN   = 4'd6;
   localparam logic [3:0] S_DIVD   = 4'd7;
   localparam logic [3:0] S_FIN    = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in      = state_ff;
      dp_cmd.op     = OP_IDLE;
      dp_cmd.commit = 1'b0;
      dp_cmd.code   = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = OP_LATCH;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (dp_stat.cmd == CMD_NONE) begin
               dp_cmd.op = OP_FINISH;
               state_in  = S_OUT;
            end else if (dp_stat.d_zero) begin
               dp_cmd.op   = OP_FINISH;
               dp_cmd.code = ST_ZDEN;
               state_in    = S_OUT;
            end else if (dp_stat.cmd == CMD_LOAD) begin
               dp_cmd.op = OP_FORM;
               state_in  = S_ZCHK;
            end else begin
               dp_cmd.op = OP_MUL0;
               state_in  = (dp_stat.cmd == CMD_ADD) ? S_MUL1 : S_FORM;
            end
         end
         S_MUL1: begin
            dp_cmd.op = OP_MUL1;
            state_in  = S_FORM;
         end
         S_FORM: begin
            dp_cmd.op = OP_FORM;
            state_in  = S_ZCHK;
         end
         S_ZCHK: begin
            if (dp_stat.rn_zero) begin
               dp_cmd.op = OP_ZERO;
               state_in  = S_FIN;
            end else begin
               dp_cmd.op = OP_GCD_INIT;
               state_in  = S_GCD;
            end
         end
         S_GCD: begin
            if (dp_stat.gcd_done) begin
               dp_cmd.op = OP_DIV_N_INIT;
               state_in  = S_DIVN;
            end else begin
               dp_cmd.op = OP_GCD_STEP;
            end
         end
         S_DIVN: begin
            if (dp_stat.div_done) begin
               dp_cmd.op = OP_DIV_D_INIT;
               state_in  = S_DIVD;
            end else begin
               dp_cmd.op = OP_DIV_STEP;
            end
         end
         S_DIVD: begin
            if (dp_stat.div_done) begin
               dp_cmd.op = OP_SAVE_QD;
               state_in  = S_FIN;
            end else begin
               dp_cmd.op = OP_DIV_STEP;
            end
         end
         S_FIN: begin
            dp_cmd.op     = OP_FINISH;
            dp_cmd.commit = dp_stat.fits;
            dp_cmd.code   = dp_stat.fits ? ST_OK : ST_OVF;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

endmodule
`default_nettype wire

// ----- rtl/rational_accumulator_add_multiply.sv -----
// ----------------------------------------------------------------------------
// rational_accumulator_add_multiply
// Fraction accumulator with load, add and multiply, kept in lowest terms.
// ----------------------------------------------------------------------------
//   channel | ports                                   | direction
//   req     | valid, stall, command, operand num/den  | in
//   rsp     | valid, stall, result num/den, status    | out
//
// Sequence: one word at a time. A rejected or unused-command word goes from
// the decide state straight to the result; a reduced word forms its fraction,
// then runs the binary gcd steps (one subtract or shift a cycle) and 128
// divider steps (numerator, then denominator, one quotient bit a cycle).
// Reset: accumulator becomes 0/1, the sequencer idles.
// Stalls: a held result blocks new words until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rational_accumulator_add_multiply_assert.svh"
module rational_accumulator_add_multiply #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_operand_numerator,
   input  logic signed [31:0] req_operand_denominator,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_numerator,
   output logic [30:0]        rsp_result_denominator,
   output logic [1:0]         rsp_status
);
   import raam_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // Sequencer: owns both handshakes
   raam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   // Datapath: accumulator, multiplier, gcd, divider, result register
   raam_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .dp_cmd                  (dp_cmd),
      .dp_stat                 (dp_stat),
      .req_command             (req_command),
      .req_operand_numerator   (req_operand_numerator),
      .req_operand_denominator (req_operand_denominator),
      .rsp_result_numerator    (rsp_result_numerator),
      .rsp_result_denominator  (rsp_result_denominator),
      .rsp_status              (rsp_status)
   );

   // Accepted word never yields a result on the very next cycle
   `RAAM_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && !req_stall, !rsp_valid, "result too early")
   // Hold off new words while a result is pending
   `RAAM_ASSERT_SAME(a_busy_on_rsp, clock, reset, rsp_valid, req_stall, "accepting while result held")
   // Drop valid after the result is taken
   `RAAM_ASSERT_NEXT(a_rsp_once, clock, reset, rsp_valid && !rsp_stall, !rsp_valid, "result repeated")
   // Denominator always positive
   `RAAM_ASSERT_SAME(a_den_pos, clock, reset, rsp_valid, rsp_result_denominator != 31'd0, "zero denominator")

endmodule
`default_nettype wire

// ----- tb/sv/rational_accumulator_add_multiply_test.sv -----
// ----------------------------------------------------------------------------
// rational_accumulator_add_multiply_test
// Drives all four commands with random idling on both channels,
// predicts each reduced fraction and status, and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module rational_accumulator_add_multiply_test;
   import raam_pkg::*;

   localparam int WIDTH = 32;
   localparam longint LIMIT_CYCLES = 2000000;

   typedef struct {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic [1:0]         status;
   } fraction_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_command = CMD_LOAD;
   logic signed [31:0] req_operand_numerator = '0;
   logic signed [31:0] req_operand_denominator = 32'sd1;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_numerator;
   logic [30:0]        rsp_result_denominator;
   logic [1:0]         rsp_status;

   // Idle percentages for the sender and the receiver.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   int unsigned error_count = 0;
   longint      cycle_count = 0;

   // Predicted accumulator.
   logic [31:0] acc_num = '0;
   logic [31:0] acc_den = 32'd1;

   fraction_word_type pending_fractions[$];

   rational_accumulator_add_multiply #(.VALUE_WIDTH(WIDTH)) i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_command            (req_command),
      .req_operand_numerator  (req_operand_numerator),
      .req_operand_denominator(req_operand_denominator),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_result_numerator   (rsp_result_numerator),
      .rsp_result_denominator (rsp_result_denominator),
      .rsp_status             (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort on a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [63:0] magnitude32(logic [31:0] raw, output bit neg);
      neg = raw[31];
      return neg ? {32'd0, -raw} : {32'd0, raw};
   endfunction

   // Compute the next accumulator and the word reported for one command.
   function automatic fraction_word_type reduce_fraction(logic [1:0] cmd, logic [31:0] c_raw,
                                                         logic [31:0] d_raw);
      fraction_word_type w;
      bit a_neg, c_neg, d_neg, r_neg;
      logic [63:0] a, b, c, d, rn, rd, t1, t2, x, y, r, lim;
      w.status = ST_OK;
      if (cmd == CMD_NONE) begin
         w.num = acc_num; w.den = acc_den[30:0];
         return w;
      end
      a = magnitude32(acc_num, a_neg);
      b = {32'd0, acc_den};
      c = magnitude32(c_raw, c_neg);
      d = magnitude32(d_raw, d_neg);
      if (d == 0) begin
         w.num = acc_num; w.den = acc_den[30:0]; w.status = ST_ZDEN;
         return w;
      end
      // Fold the operand denominator sign into the numerator.
      c_neg = c_neg ^ d_neg;
      if (cmd == CMD_LOAD) begin
         r_neg = c_neg; rn = c; rd = d;
      end else if (cmd == CMD_MUL) begin
         r_neg = a_neg ^ c_neg; rn = a * c; rd = b * d;
      end else begin
         t1 = a * d; t2 = c * b;
         if (a_neg == c_neg) begin
            r_neg = a_neg; rn = t1 + t2;
         end else if (t1 >= t2) begin
            r_neg = a_neg; rn = t1 - t2;
         end else begin
            r_neg = c_neg; rn = t2 - t1;
         end
         rd = b * d;
      end
      if (rn == 0) begin
         r_neg = 0; rd = 1;
      end else begin
         x = rn; y = rd;
         while (y != 0) begin
            r = x % y; x = y; y = r;
         end
         rn = rn / x; rd = rd / x;
      end
      lim = 64'd1 << (WIDTH - 1);
      if (rd > lim - 1 || rn > (r_neg ? lim : lim - 1)) begin
         w.num = acc_num; w.den = acc_den[30:0]; w.status = ST_OVF;
         return w;
      end
      acc_num = r_neg ? -rn[31:0] : rn[31:0];
      acc_den = rd[31:0];
      w.num = acc_num; w.den = acc_den[30:0];
      return w;
   endfunction

   // Send one word, idle randomly first, and hold it until accepted.
   task automatic send_word(logic [1:0] cmd, logic [31:0] num, logic [31:0] den);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_operand_numerator <= num;
      req_operand_denominator <= den;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_fractions.push_back(reduce_fraction(cmd, num, den));
   endtask

   // Receiver: random stalls, compare each accepted word.
   always @(posedge clock) begin
      fraction_word_type w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_fractions.size() == 0) begin
               $error("unexpected result word");
               error_count++;
            end else begin
               w = pending_fractions.pop_front();
               if (rsp_result_numerator !== w.num) begin
                  $error("result_numerator expected %0d actual %0d", w.num,
                         rsp_result_numerator);
                  error_count++;
               end
               if (rsp_result_denominator !== w.den) begin
                  $error("result_denominator expected %0d actual %0d", w.den,
                         rsp_result_denominator);
                  error_count++;
               end
               if (rsp_status !== w.status) begin
                  $error("status expected %0d actual %0d", w.status, rsp_status);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(20);
         2: return -$urandom_range(20);
         3: return {1'b0, 31'h7FFFFFFF} - $urandom_range(3);
         4: return 32'h80000000 + $urandom_range(3);
         default: return $urandom_range(1000) - 500;
      endcase
   endfunction

   function automatic logic [31:0] pick_den();
      if ($urandom_range(29) == 0) return '0;
      return pick_value();
   endfunction

   // Extremes, every command and each special case.
   task automatic test_directed();
      send_word(CMD_LOAD, 32'sd3, 32'sd6);
      send_word(CMD_ADD, 32'sd1, 32'sd3);
      send_word(CMD_MUL, -32'sd4, 32'sd5);
      send_word(CMD_ADD, 32'sd4, 32'sd5);
      send_word(CMD_LOAD, 32'sd7, -32'sd2);   // sign moves to the numerator
      send_word(CMD_LOAD, 32'sd5, 32'sd0);    // zero denominator on each command
      send_word(CMD_ADD, 32'sd5, 32'sd0);
      send_word(CMD_MUL, 32'sd5, 32'sd0);
      send_word(CMD_NONE, 32'sd9, 32'sd9);    // unused command
      send_word(CMD_LOAD, 32'sd1, 32'h80000000); // too-large denominator
      send_word(CMD_LOAD, 32'h80000000, 32'sd1);
      send_word(CMD_MUL, 32'sd2, 32'sd1);     // numerator overflow
      send_word(CMD_LOAD, 32'h80000000, 32'h80000000);
      send_word(CMD_LOAD, 32'h7FFFFFFF, 32'h7FFFFFFE);
      send_word(CMD_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_word(CMD_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_word(CMD_LOAD, 32'h80000000, 32'hFFFFFFFF); // +2^31 overflows
      send_word(CMD_LOAD, 32'sd0, 32'h7FFFFFFF);
      send_word(CMD_ADD, 32'h7FFFFFFF, 32'sd1);
   endtask

   // Random words, mostly useful commands, with occasional resyncing loads.
   task automatic test_random(int count);
      logic [1:0] cmd;
      for (int i = 0; i < count; i++) begin
         cmd = 2'($urandom_range(3));
         if (cmd == CMD_NONE && $urandom_range(3) != 0) cmd = CMD_ADD;
         send_word(cmd, pick_value(), pick_den());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 34; recv_idle_pct = 45;
      test_random(250);
      send_idle_pct = 45; recv_idle_pct = 34;
      test_random(250);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(250);
      req_valid <= 1'b0;
      while (pending_fractions.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (error_count == 0 && pending_fractions.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/raam_pkg.sv
rtl/raam_datapath.sv
rtl/raam_ctrl.sv
rtl/rational_accumulator_add_multiply.sv
tb/sv/rational_accumulator_add_multiply_test.sv
